// ===== design/prdb_pkg.sv =====
// Package for the packet reorder / dedup buffer: widths and defaults.
// No dependencies.
package prdb_pkg;
    localparam int HeapDepthDefault = 64;
    localparam int SeqBitsDefault   = 16;
    localparam int FieldBits        = 16;
    localparam int WaitBits         = 6;
    localparam logic [WaitBits-1:0] WaitDepthReset = 6'd8;
    localparam logic [0:0] RegWaitDepth = 1'b0;
endpackage

// ===== design/prdb_heap.sv =====
// Heap engine: one synchronous entry memory, insert by sift-up, pop by sift-down.
// Depends on prdb_pkg.
module prdb_heap #(
    parameter int HEAP_DEPTH = prdb_pkg::HeapDepthDefault,
    parameter int SEQ_BITS   = prdb_pkg::SeqBitsDefault
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [SEQ_BITS-1:0]              in_seq,
    input  logic [prdb_pkg::FieldBits-1:0]   in_handle,
    input  logic [prdb_pkg::WaitBits-1:0]    wait_depth,
    output logic                             busy,
    output logic                             done,
    output logic                             pop_valid,
    output logic [SEQ_BITS-1:0]              pop_seq,
    output logic [prdb_pkg::FieldBits-1:0]   pop_handle
);
    localparam int IW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int OW = $clog2(HEAP_DEPTH + 1);
    localparam int EW = SEQ_BITS + prdb_pkg::FieldBits;

    localparam logic [3:0] S_IDLE = 4'd0, S_RROOT = 4'd1, S_ROOTW = 4'd2,
        S_RLAST = 4'd3, S_DNRD = 4'd4, S_DNL = 4'd5, S_DNR = 4'd6, S_DNCMP = 4'd7,
        S_INS = 4'd8, S_UPRD = 4'd9, S_UPCMP = 4'd10, S_CHK = 4'd11, S_FIN = 4'd12;

    function automatic logic later(input logic [SEQ_BITS-1:0] a, b);
        logic [SEQ_BITS-1:0] d;
        d = a - b;
        return (d != '0) && !d[SEQ_BITS-1];
    endfunction

    logic [EW-1:0] mem [HEAP_DEPTH];
    logic [EW-1:0] rd_q;
    logic [IW-1:0] ra;
    logic          we;
    logic [IW-1:0] wa;
    logic [EW-1:0] wd;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_q <= mem[ra];
    end

    logic [3:0]    state_reg;
    logic [OW-1:0] occ_reg;
    logic [IW-1:0] idx_reg, cidx_reg;
    logic [EW-1:0] cur_reg, lch_reg, new_reg;
    logic          pend_ins_reg;  // insert still to do after a full-heap pop
    logic [OW:0]   l_w;
    logic [OW:0]   r_w;

    assign busy = (state_reg != S_IDLE);
    assign l_w = (OW+1)'({idx_reg, 1'b1});
    assign r_w = l_w + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            done         <= 1'b0;
            pop_valid    <= 1'b0;
            pend_ins_reg <= 1'b0;
        end
        else
        begin
            done      <= 1'b0;
            pop_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        new_reg <= {in_handle, in_seq};
                        if (occ_reg == OW'(HEAP_DEPTH))
                        begin
                            pend_ins_reg <= 1'b1;
                            state_reg    <= S_RROOT;
                        end
                        else
                        begin
                            pend_ins_reg <= 1'b0;
                            state_reg    <= S_INS;
                        end
                    end
                end
                S_INS:
                begin
                    idx_reg   <= occ_reg[IW-1:0];
                    cur_reg   <= new_reg;
                    occ_reg   <= occ_reg + 1'b1;
                    state_reg <= (occ_reg == '0) ? S_CHK : S_UPRD;
                end
                S_UPRD: state_reg <= S_UPCMP;
                S_UPCMP:
                begin
                    if (later(rd_q[SEQ_BITS-1:0], cur_reg[SEQ_BITS-1:0]))
                    begin
                        idx_reg   <= (idx_reg - 1'b1) >> 1;
                        state_reg <= (((idx_reg - 1'b1) >> 1) == '0) ? S_CHK : S_UPRD;
                    end
                    else
                        state_reg <= pend_ins_reg ? S_FIN : S_CHK;
                end
                S_CHK:
                begin
                    if (pend_ins_reg)
                        state_reg <= S_FIN;
                    else if (occ_reg > {{(OW-prdb_pkg::WaitBits > 0 ? OW-prdb_pkg::WaitBits : 0){1'b0}}, wait_depth})
                        state_reg <= S_RROOT;
                    else
                        state_reg <= S_FIN;
                end
                S_RROOT: state_reg <= S_ROOTW;
                S_ROOTW:
                begin
                    pop_valid  <= 1'b1;
                    pop_seq    <= rd_q[SEQ_BITS-1:0];
                    pop_handle <= rd_q[EW-1:SEQ_BITS];
                    occ_reg    <= occ_reg - 1'b1;
                    idx_reg    <= '0;
                    state_reg  <= (occ_reg == OW'(1)) ? S_RLAST : S_RLAST;
                end
                S_RLAST:
                begin
                    if (occ_reg == '0)
                        state_reg <= pend_ins_reg ? S_INS : S_FIN;
                    else
                    begin
                        cur_reg   <= rd_q;
                        state_reg <= S_DNRD;
                    end
                end
                S_DNRD:
                begin
                    if (l_w >= {1'b0, occ_reg})
                        state_reg <= S_DNCMP;
                    else
                        state_reg <= S_DNL;
                end
                S_DNL:
                begin
                    lch_reg   <= rd_q;
                    cidx_reg  <= l_w[IW-1:0];
                    state_reg <= (r_w < {1'b0, occ_reg}) ? S_DNR : S_DNCMP;
                end
                S_DNR:
                begin
                    if (later(lch_reg[SEQ_BITS-1:0], rd_q[SEQ_BITS-1:0]))
                    begin
                        lch_reg  <= rd_q;
                        cidx_reg <= r_w[IW-1:0];
                    end
                    state_reg <= S_DNCMP;
                end
                S_DNCMP:
                begin
                    if (l_w < {1'b0, occ_reg}
                        && later(cur_reg[SEQ_BITS-1:0], lch_reg[SEQ_BITS-1:0]))
                    begin
                        idx_reg   <= cidx_reg;
                        state_reg <= S_DNRD;
                    end
                    else
                        state_reg <= pend_ins_reg ? S_INS : S_FIN;
                end
                S_FIN:
                begin
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Memory port steering per state
    always_comb
    begin
        ra = '0;
        we = 1'b0;
        wa = idx_reg;
        wd = cur_reg;
        case (state_reg)
            S_INS:
            begin
                we = 1'b1;
                wa = occ_reg[IW-1:0];
                wd = new_reg;
            end
            S_UPRD: ra = (idx_reg - 1'b1) >> 1;
            S_UPCMP:
            begin
                if (later(rd_q[SEQ_BITS-1:0], cur_reg[SEQ_BITS-1:0]))
                begin
                    // parent moves down, new entry moves up
                    we = 1'b1;
                    wa = idx_reg;
                    wd = rd_q;
                end
                else
                begin
                    we = 1'b1;
                    wa = idx_reg;
                    wd = cur_reg;
                end
            end
            S_CHK:
            begin
                we = 1'b1;
                wa = idx_reg;
                wd = cur_reg;
            end
            S_RROOT: ra = '0;
            S_ROOTW: ra = IW'(occ_reg - 1'b1);
            S_DNRD:  ra = l_w[IW-1:0];
            S_DNL:   ra = r_w[IW-1:0];
            S_DNCMP:
            begin
                we = 1'b1;
                wa = idx_reg;
                if (l_w < {1'b0, occ_reg}
                    && later(cur_reg[SEQ_BITS-1:0], lch_reg[SEQ_BITS-1:0]))
                    wd = lch_reg;
                else
                    wd = cur_reg;
            end
            default: ;
        endcase
    end

    ap_occ: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(HEAP_DEPTH)) else $error("occupancy overflow");
    ap_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !pop_valid) else $error("pop after done");
    ap_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("start ignored");
endmodule

// ===== design/prdb_release.sv =====
// Release filter: expected sequence, first-release flag, gap flag, output register.
// Depends on prdb_pkg.
module prdb_release #(
    parameter int SEQ_BITS = prdb_pkg::SeqBitsDefault
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    input  logic [SEQ_BITS-1:0]            pop_seq,
    input  logic [prdb_pkg::FieldBits-1:0] pop_handle,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [prdb_pkg::FieldBits-1:0] out_seq,
    output logic [prdb_pkg::FieldBits-1:0] out_handle,
    output logic                           out_gap
);
    function automatic logic later(input logic [SEQ_BITS-1:0] a, b);
        logic [SEQ_BITS-1:0] d;
        d = a - b;
        return (d != '0) && !d[SEQ_BITS-1];
    endfunction

    logic [SEQ_BITS-1:0] exp_reg;
    logic                first_reg;
    logic                take;

    assign take = pop_valid && (first_reg || !later(exp_reg, pop_seq));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg   <= '0;
            first_reg <= 1'b1;
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (take)
            begin
                out_valid  <= 1'b1;
                out_seq    <= prdb_pkg::FieldBits'(pop_seq);
                out_handle <= pop_handle;
                out_gap    <= later(pop_seq, exp_reg);
                exp_reg    <= pop_seq + 1'b1;
                first_reg  <= 1'b0;
            end
        end
    end

    ap_first: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> !first_reg) else $error("first flag stuck");
    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable({out_seq, out_handle, out_gap}))
        else $error("beat changed while stalled");
    ap_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid |-> !out_valid) else $error("pop while a beat waits");
endmodule

// ===== design/packet_reorder_dedup_buffer.sv =====
// Top level of the packet reorder / dedup buffer: stream ports, APB register.
// Depends on prdb_pkg, prdb_heap, prdb_release.
//
// channel   | dir | beat contents
// s_axis    | in  | tdata[15:0] seq_number, [31:16] payload_handle
// m_axis    | out | tdata[15:0] out_seq_number, [31:16] out_payload_handle; tuser gap_skipped
// apb       | in  | reg 0 @0x0 wait_depth[5:0]
//
// One descriptor is worked through in full before the next is taken: sifting up visits
// S_UPRD and S_UPCMP per level, sifting down S_DNRD, S_DNL, S_DNR and S_DNCMP, set by the
// heap memory (one read port and one write port) walking the tree.
// Reset clears control only; heap entries are written before they are read.
// s_axis_tready drops while a descriptor is in work or a result waits unread.
module packet_reorder_dedup_buffer #(
    parameter int HEAP_DEPTH = prdb_pkg::HeapDepthDefault,
    parameter int SEQ_BITS   = prdb_pkg::SeqBitsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // seq_number, payload_handle
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_seq_number, out_payload_handle
    output logic        m_axis_tuser,   // gap_skipped
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [prdb_pkg::WaitBits-1:0] wait_reg;
    logic busy, done, pop_valid, in_take;
    logic [SEQ_BITS-1:0] pop_seq;
    logic [prdb_pkg::FieldBits-1:0] pop_handle, o_seq, o_handle;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == prdb_pkg::RegWaitDepth) ? {26'd0, wait_reg} : 32'd0;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wait_reg <= prdb_pkg::WaitDepthReset;
        else if (psel && penable && pwrite && paddr[2] == prdb_pkg::RegWaitDepth)
            wait_reg <= pwdata[prdb_pkg::WaitBits-1:0];
    end

    assign s_axis_tready = !busy && !m_axis_tvalid;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    prdb_heap #(.HEAP_DEPTH(HEAP_DEPTH), .SEQ_BITS(SEQ_BITS)) u_heap (
        .clk(clk), .rst_n(rst_n), .start(in_take),
        .in_seq(s_axis_tdata[SEQ_BITS-1:0]), .in_handle(s_axis_tdata[31:16]),
        .wait_depth(wait_reg), .busy(busy), .done(done),
        .pop_valid(pop_valid), .pop_seq(pop_seq), .pop_handle(pop_handle)
    );

    prdb_release #(.SEQ_BITS(SEQ_BITS)) u_rel (
        .clk(clk), .rst_n(rst_n), .pop_valid(pop_valid), .pop_seq(pop_seq),
        .pop_handle(pop_handle), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_seq(o_seq), .out_handle(o_handle), .out_gap(m_axis_tuser)
    );

    assign m_axis_tdata = {o_handle, o_seq};

    ap_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> busy) else $error("accept without work");
    ap_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy || done) |-> !(busy && in_take)) else $error("accept during work");
    ap_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept while a beat waits");
endmodule

// ===== sim/tb_packet_reorder_dedup_buffer.sv =====
// Testbench for packet_reorder_dedup_buffer: streams descriptors, predicts releases
// with a serial-order min-heap model, checks every released beat. Depends on prdb_pkg and packet_reorder_dedup_buffer.
`timescale 1ns / 1ps

class release_scoreboard;
    localparam int Depth = 64;
    bit [15:0] heap_seq [Depth];
    bit [15:0] heap_tag [Depth];
    int        count;
    bit [15:0] next_seq;
    bit        first_out;
    bit [5:0]  hold_depth;
    bit [32:0] pending_q [$];
    int        mismatches;

    function new();
        count = 0;
        next_seq = 16'd0;
        first_out = 1'b1;
        hold_depth = prdb_pkg::WaitDepthReset;
        mismatches = 0;
    endfunction

    // a later than b in 16-bit serial order
    function bit is_later(bit [15:0] a, bit [15:0] b);
        bit [15:0] d;
        d = a - b;
        return d != 16'd0 && d < 16'h8000;
    endfunction

    function void swap_slots(int i, int j);
        bit [15:0] s;
        bit [15:0] t;
        s = heap_seq[i];
        t = heap_tag[i];
        heap_seq[i] = heap_seq[j];
        heap_tag[i] = heap_tag[j];
        heap_seq[j] = s;
        heap_tag[j] = t;
    endfunction

    function void push(bit [15:0] s, bit [15:0] t);
        int i;
        int p;
        i = count;
        heap_seq[i] = s;
        heap_tag[i] = t;
        count++;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!is_later(heap_seq[p], heap_seq[i]))
                break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function void pop_oldest();
        bit [15:0] s;
        int i;
        int l;
        int c;
        if (count == 0)
            return;
        s = heap_seq[0];
        if (first_out || !is_later(next_seq, s))
        begin
            pending_q.push_back({is_later(s, next_seq), heap_tag[0], s});
            next_seq = s + 16'd1;
            first_out = 1'b0;
        end
        count--;
        if (count == 0)
            return;
        heap_seq[0] = heap_seq[count];
        heap_tag[0] = heap_tag[count];
        i = 0;
        forever
        begin
            l = 2 * i + 1;
            if (l >= count)
                break;
            c = l;
            if (l + 1 < count && is_later(heap_seq[l], heap_seq[l + 1]))
                c = l + 1;
            if (!is_later(heap_seq[i], heap_seq[c]))
                break;
            swap_slots(i, c);
            i = c;
        end
    endfunction

    function void note_input(bit [15:0] s, bit [15:0] t);
        if (count >= Depth)
        begin
            pop_oldest();
            push(s, t);
        end
        else
        begin
            push(s, t);
            if (count > hold_depth)
                pop_oldest();
        end
    endfunction

    function void check_beat(bit [31:0] data, bit gap);
        bit [32:0] exp_beat;
        if (pending_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected beat data=%h gap=%b", data, gap);
            return;
        end
        exp_beat = pending_q.pop_front();
        if (exp_beat[31:0] !== data || exp_beat[32] !== gap)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp seq=%h tag=%h gap=%b, got seq=%h tag=%h gap=%b",
                    exp_beat[15:0], exp_beat[31:16], exp_beat[32],
                    data[15:0], data[31:16], gap);
        end
    endfunction
endclass

module tb_packet_reorder_dedup_buffer;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    release_scoreboard sb = new();
    int  cycles = 0;
    int  hold_off = 0;
    bit  sink_stall_long = 1'b0;
    bit [15:0] seq_base = 16'd0;

    packet_reorder_dedup_buffer dut (.*);

    always #1 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 900000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tuser);
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_stall_long)
        begin
            hold_off <= 3000;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 4)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // gap after a beat; valid drops only when the gap is not empty
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_desc(bit [15:0] s, bit [15:0] t);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {t, s};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(s, t);
        idle_gap();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_depth(bit [5:0] d);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * prdb_pkg::RegWaitDepth);
        pwdata <= {26'd0, d};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.hold_depth = d;
    endtask

    // mostly near-sequential with duplicates and reordering, some noise
    task automatic random_phase(int n);
        bit [15:0] s;
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0: s = 16'($urandom);
                1, 2: s = seq_base - 16'($urandom_range(0, 6));
                default: s = seq_base + 16'($urandom_range(0, 4));
            endcase
            seq_base = seq_base + 16'($urandom_range(0, 2));
            send_desc(s, 16'($urandom));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, duplicates, half-range distance, wrap
        send_desc(16'h8000, 16'hFFFF);
        send_desc(16'h0000, 16'h0000);
        send_desc(16'hFFFF, 16'hA5A5);
        send_desc(16'h0000, 16'h5A5A);
        send_desc(16'h0001, 16'h1234);
        send_desc(16'h0001, 16'h4321);
        send_desc(16'h7FFF, 16'h0F0F);
        send_desc(16'h0003, 16'hF0F0);
        send_desc(16'h0002, 16'h0001);
        send_desc(16'h0005, 16'h8000);
        send_desc(16'h0004, 16'h00FF);
        drain();
        write_depth(6'd0);
        send_desc(16'h0010, 16'h1111);
        send_desc(16'h0010, 16'h2222);
        send_desc(16'h000F, 16'h3333);
        send_desc(16'h8011, 16'h4444);
        send_desc(16'h0012, 16'h5555);
        send_desc(16'h0020, 16'h6666);
        drain();
        seq_base = 16'hFFF0;

        write_depth(6'd1);
        random_phase(60);
        drain();
        write_depth(6'd63);
        random_phase(80);
        drain();
        write_depth(6'd4);
        // receiver holds off while the sender keeps offering
        sink_stall_long = 1'b1;
        wait (hold_off > 0);
        sink_stall_long = 1'b0;
        random_phase(80);
        drain();
        write_depth(6'd0);
        random_phase(60);
        drain();
        write_depth(6'd12);
        random_phase(80);
        drain();
        write_depth(6'd8);
        random_phase(40);
        drain();

        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
